// ----- design/fraction_sum_reducer_defines.svh -----
// ----------------------------------------------------------------------------
// Fraction sum reducer assertion macros
// Shared property templates for the checker of the fraction sum reducer.
// ----------------------------------------------------------------------------
`ifndef FRACTION_SUM_REDUCER_DEFINES_SVH
`define FRACTION_SUM_REDUCER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FSR_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FSR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/fsr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fraction sum reducer package
// Status codes and numeric limits shared by the reducer and its checker.
// ----------------------------------------------------------------------------
package fsr_pkg;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_ZERO_DEN = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    localparam logic [63:0] MAX_POS  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SIGN_MAG = 64'h8000_0000_0000_0000;

endpackage

// ----- design/fraction_sum_reducer.sv -----
`timescale 1ns / 1ps
// Sequence: a fraction runs from its transfer to ready again through a binary GCD, two divisions
// and three multiplications, then the add; an error ends sooner.
// A last one then emits a zero or error total directly, else runs a second GCD and two divisions,
// and then waits, if need be, for the output register to free up.
// Throughput: one fraction at a time; all steps go through one shared 66-bit adder.
// Reset (aresetn low, synchronous) clears the sum to 0/1, the sticky error and m_valid.
// ----------------------------------------------------------------------------
// Fraction sum reducer
// Accumulates signed fractions over a common denominator and emits the
// total in lowest terms on the last fraction of each run.
// ----------------------------------------------------------------------------
module fraction_sum_reducer
    import fsr_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_numerator,
    input  logic signed [31:0] s_denominator,
    input  logic               s_last,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [63:0] m_sum_numerator,
    output logic        [62:0] m_sum_denominator,
    output logic        [1:0]  m_status
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_RUN,
        ST_ADD,
        ST_REDUCE,
        ST_EMIT
    } state_t;

    typedef enum logic [3:0] {
        PH_GCD_DEN,
        PH_DIV_Q,
        PH_DIV_F,
        PH_MUL_L,
        PH_MUL_T1,
        PH_MUL_T2,
        PH_GCD_SUM,
        PH_DIV_RN,
        PH_DIV_RD
    } phase_t;

    typedef enum logic [1:0] {
        MODE_GCD,
        MODE_DIV,
        MODE_MUL
    } mode_t;

    function automatic logic [63:0] mag64(input logic [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    mode_t  mode;

    logic [63:0] acc_num_reg, acc_num_next;
    logic [63:0] acc_den_reg, acc_den_next;
    logic [1:0]  err_reg, err_next;
    logic [63:0] num_reg, num_next;
    logic [63:0] den_reg, den_next;
    logic        last_reg, last_next;
    logic        item_ovf_reg, item_ovf_next;
    logic [63:0] g_reg, g_next;
    logic [63:0] q_reg, q_next;
    logic [63:0] f_reg, f_next;
    logic [63:0] l_reg, l_next;
    logic [63:0] t1_reg, t1_next;
    logic [63:0] t2_reg, t2_next;

    // Shared iterative unit: GCD, restoring divide and MSB-first multiply.
    logic [63:0] ua_reg, ua_next;
    logic [63:0] ub_reg, ub_next;
    logic [65:0] up_reg, up_next;
    logic [6:0]  ucnt_reg, ucnt_next;
    logic [5:0]  ushift_reg, ushift_next;
    logic        ulim_reg, ulim_next;
    logic        uovf_reg, uovf_next;

    logic [63:0] res_num_reg, res_num_next;
    logic [62:0] res_den_reg, res_den_next;
    logic [1:0]  res_st_reg, res_st_next;

    logic        m_valid_reg, m_valid_next;
    logic [63:0] m_num_reg, m_num_next;
    logic [62:0] m_den_reg, m_den_next;
    logic [1:0]  m_st_reg, m_st_next;

    logic [64:0] div_rs;
    logic [65:0] add_x, add_y, add_sum;
    logic        add_cin;
    logic        unit_done;
    logic [63:0] gcd_result;
    logic [65:0] mul_limit;

    always_comb begin
        case (phase_reg)
            PH_GCD_DEN, PH_GCD_SUM: mode = MODE_GCD;
            PH_DIV_Q, PH_DIV_F, PH_DIV_RN, PH_DIV_RD: mode = MODE_DIV;
            default: mode = MODE_MUL;
        endcase
    end

    assign div_rs     = {up_reg[63:0], ua_reg[63]};
    assign gcd_result = ub_reg << ushift_reg;
    assign mul_limit  = {2'b00, (ulim_reg ? SIGN_MAG : MAX_POS)};
    assign unit_done  = (mode == MODE_GCD) ? (ua_reg == 64'd0) : ucnt_reg[6];

    // Operand selection for the one wide adder.
    always_comb begin
        add_x   = {2'b00, ua_reg};
        add_y   = ~{2'b00, ub_reg};
        add_cin = 1'b1;
        if (state_reg == ST_ADD) begin
            add_x   = {2'b00, t1_reg};
            add_y   = {2'b00, t2_reg};
            add_cin = 1'b0;
        end else begin
            case (mode)
                MODE_DIV: begin
                    add_x   = {1'b0, div_rs};
                    add_y   = ~{2'b00, ub_reg};
                    add_cin = 1'b1;
                end
                MODE_MUL: begin
                    add_x   = {up_reg[64:0], 1'b0};
                    add_y   = {2'b00, (ua_reg[63] ? ub_reg : 64'd0)};
                    add_cin = 1'b0;
                end
                default: begin
                    add_x   = {2'b00, ua_reg};
                    add_y   = ~{2'b00, ub_reg};
                    add_cin = 1'b1;
                end
            endcase
        end
    end

    assign add_sum = add_x + add_y + {65'd0, add_cin};

    always_comb begin
        logic        load_en;
        phase_t      load_phase;
        logic [63:0] load_a;
        logic [63:0] load_b;
        logic        load_lim;
        logic [63:0] dm;
        logic [63:0] nm;
        logic [63:0] s;

        load_en    = 1'b0;
        load_phase = PH_GCD_DEN;
        load_a     = 64'd0;
        load_b     = 64'd0;
        load_lim   = 1'b0;
        dm         = den_reg;
        nm         = num_reg;
        s          = add_sum[63:0];

        state_next    = state_reg;
        phase_next    = phase_reg;
        acc_num_next  = acc_num_reg;
        acc_den_next  = acc_den_reg;
        err_next      = err_reg;
        num_next      = num_reg;
        den_next      = den_reg;
        last_next     = last_reg;
        item_ovf_next = item_ovf_reg;
        g_next        = g_reg;
        q_next        = q_reg;
        f_next        = f_reg;
        l_next        = l_reg;
        t1_next       = t1_reg;
        t2_next       = t2_reg;
        ua_next       = ua_reg;
        ub_next       = ub_reg;
        up_next       = up_reg;
        ucnt_next     = ucnt_reg;
        ushift_next   = ushift_reg;
        ulim_next     = ulim_reg;
        uovf_next     = uovf_reg;
        res_num_next  = res_num_reg;
        res_den_next  = res_den_reg;
        res_st_next   = res_st_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_num_next    = m_num_reg;
        m_den_next    = m_den_reg;
        m_st_next     = m_st_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    num_next   = {{32{s_numerator[31]}}, s_numerator};
                    den_next   = {{32{s_denominator[31]}}, s_denominator};
                    last_next  = s_last;
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                item_ovf_next = 1'b0;
                if (err_reg != STATUS_OK) begin
                    state_next = ST_REDUCE;
                end else if (den_reg == 64'd0) begin
                    err_next   = STATUS_ZERO_DEN;
                    state_next = ST_REDUCE;
                end else begin
                    // The sign of the denominator moves onto the numerator.
                    if (den_reg[63]) begin
                        dm = 64'd0 - den_reg;
                        nm = 64'd0 - num_reg;
                    end
                    den_next   = dm;
                    num_next   = nm;
                    load_en    = 1'b1;
                    load_phase = PH_GCD_DEN;
                    load_a     = acc_den_reg;
                    load_b     = dm;
                end
            end
            ST_RUN: begin
                if (!unit_done) begin
                    case (mode)
                        MODE_GCD: begin
                            if (!ua_reg[0] && !ub_reg[0]) begin
                                ua_next     = ua_reg >> 1;
                                ub_next     = ub_reg >> 1;
                                ushift_next = ushift_reg + 6'd1;
                            end else if (!ua_reg[0]) begin
                                ua_next = ua_reg >> 1;
                            end else if (!ub_reg[0]) begin
                                ub_next = ub_reg >> 1;
                            end else if (!add_sum[65]) begin
                                ua_next = add_sum[63:0];
                            end else begin
                                ua_next = ub_reg;
                                ub_next = ua_reg;
                            end
                        end
                        MODE_DIV: begin
                            up_next   = add_sum[65] ? {1'b0, div_rs} : add_sum;
                            ua_next   = {ua_reg[62:0], !add_sum[65]};
                            ucnt_next = ucnt_reg + 7'd1;
                        end
                        default: begin
                            // The partial product only grows, so crossing the
                            // limit once means the full product overflows.
                            if (!uovf_reg) begin
                                up_next   = add_sum;
                                uovf_next = (add_sum > mul_limit);
                            end
                            ua_next   = {ua_reg[62:0], 1'b0};
                            ucnt_next = ucnt_reg + 7'd1;
                        end
                    endcase
                end else begin
                    case (phase_reg)
                        PH_GCD_DEN: begin
                            g_next     = gcd_result;
                            load_en    = 1'b1;
                            load_phase = PH_DIV_Q;
                            load_a     = acc_den_reg;
                            load_b     = gcd_result;
                        end
                        PH_DIV_Q: begin
                            q_next     = ua_reg;
                            load_en    = 1'b1;
                            load_phase = PH_DIV_F;
                            load_a     = den_reg;
                            load_b     = g_reg;
                        end
                        PH_DIV_F: begin
                            f_next     = ua_reg;
                            load_en    = 1'b1;
                            load_phase = PH_MUL_L;
                            load_a     = q_reg;
                            load_b     = den_reg;
                        end
                        PH_MUL_L: begin
                            if (uovf_reg) begin
                                err_next   = STATUS_OVERFLOW;
                                state_next = ST_REDUCE;
                            end else begin
                                l_next     = up_reg[63:0];
                                load_en    = 1'b1;
                                load_phase = PH_MUL_T1;
                                load_a     = f_reg;
                                load_b     = mag64(acc_num_reg);
                                load_lim   = acc_num_reg[63];
                            end
                        end
                        PH_MUL_T1: begin
                            item_ovf_next = uovf_reg;
                            t1_next    = acc_num_reg[63] ? (64'd0 - up_reg[63:0])
                                                         : up_reg[63:0];
                            load_en    = 1'b1;
                            load_phase = PH_MUL_T2;
                            load_a     = q_reg;
                            load_b     = mag64(num_reg);
                            load_lim   = num_reg[63];
                        end
                        PH_MUL_T2: begin
                            item_ovf_next = item_ovf_reg | uovf_reg;
                            t2_next    = num_reg[63] ? (64'd0 - up_reg[63:0])
                                                     : up_reg[63:0];
                            state_next = ST_ADD;
                        end
                        PH_GCD_SUM: begin
                            g_next     = gcd_result;
                            load_en    = 1'b1;
                            load_phase = PH_DIV_RN;
                            load_a     = mag64(acc_num_reg);
                            load_b     = gcd_result;
                        end
                        PH_DIV_RN: begin
                            q_next     = ua_reg;
                            load_en    = 1'b1;
                            load_phase = PH_DIV_RD;
                            load_a     = acc_den_reg;
                            load_b     = g_reg;
                        end
                        default: begin
                            res_num_next = acc_num_reg[63] ? (64'd0 - q_reg) : q_reg;
                            res_den_next = ua_reg[62:0];
                            res_st_next  = STATUS_OK;
                            state_next   = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_ADD: begin
                if (item_ovf_reg ||
                    ((t1_reg[63] == t2_reg[63]) && (s[63] != t1_reg[63]))) begin
                    err_next = STATUS_OVERFLOW;
                end else begin
                    acc_num_next = s;
                    acc_den_next = l_reg;
                end
                state_next = ST_REDUCE;
            end
            ST_REDUCE: begin
                if (!last_reg) begin
                    state_next = ST_IDLE;
                end else if (err_reg != STATUS_OK) begin
                    res_num_next = 64'd0;
                    res_den_next = 63'd0;
                    res_st_next  = err_reg;
                    state_next   = ST_EMIT;
                end else if (acc_num_reg == 64'd0) begin
                    res_num_next = 64'd0;
                    res_den_next = 63'd1;
                    res_st_next  = STATUS_OK;
                    state_next   = ST_EMIT;
                end else begin
                    load_en    = 1'b1;
                    load_phase = PH_GCD_SUM;
                    load_a     = mag64(acc_num_reg);
                    load_b     = acc_den_reg;
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_num_next   = res_num_reg;
                    m_den_next   = res_den_reg;
                    m_st_next    = res_st_reg;
                    acc_num_next = 64'd0;
                    acc_den_next = 64'd1;
                    err_next     = STATUS_OK;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (load_en) begin
            phase_next  = load_phase;
            ua_next     = load_a;
            ub_next     = load_b;
            up_next     = 66'd0;
            ucnt_next   = 7'd0;
            ushift_next = 6'd0;
            ulim_next   = load_lim;
            uovf_next   = 1'b0;
            state_next  = ST_RUN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_GCD_DEN;
            acc_num_reg <= 64'd0;
            acc_den_reg <= 64'd1;
            err_reg     <= STATUS_OK;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            acc_num_reg <= acc_num_next;
            acc_den_reg <= acc_den_next;
            err_reg     <= err_next;
            m_valid_reg <= m_valid_next;
        end
        num_reg      <= num_next;
        den_reg      <= den_next;
        last_reg     <= last_next;
        item_ovf_reg <= item_ovf_next;
        g_reg        <= g_next;
        q_reg        <= q_next;
        f_reg        <= f_next;
        l_reg        <= l_next;
        t1_reg       <= t1_next;
        t2_reg       <= t2_next;
        ua_reg       <= ua_next;
        ub_reg       <= ub_next;
        up_reg       <= up_next;
        ucnt_reg     <= ucnt_next;
        ushift_reg   <= ushift_next;
        ulim_reg     <= ulim_next;
        uovf_reg     <= uovf_next;
        res_num_reg  <= res_num_next;
        res_den_reg  <= res_den_next;
        res_st_reg   <= res_st_next;
        m_num_reg    <= m_num_next;
        m_den_reg    <= m_den_next;
        m_st_reg     <= m_st_next;
    end

    assign s_ready           = (state_reg == ST_IDLE);
    assign m_valid           = m_valid_reg;
    assign m_sum_numerator   = m_num_reg;
    assign m_sum_denominator = m_den_reg;
    assign m_status          = m_st_reg;

endmodule

// ----- design/fsr_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fraction sum reducer checker
// Port-level properties of the reducer's inputs and results, bound into the reducer.
// ----------------------------------------------------------------------------
`include "fraction_sum_reducer_defines.svh"

module fsr_checker
    import fsr_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [31:0] s_numerator,
    input logic [31:0] s_denominator,
    input logic        s_last,
    input logic        m_valid,
    input logic        m_ready,
    input logic [63:0] m_sum_numerator,
    input logic [62:0] m_sum_denominator,
    input logic [1:0]  m_status
);

    logic in_xfer;
    logic [64:0] in_word;

    // Input side ties the checker to every port and is checked for unknown bits.
    assign in_xfer = s_valid && s_ready;
    assign in_word = {s_numerator, s_denominator, s_last};

    // A good result always carries a positive denominator.
    `FSR_ASSERT_SAME(a_ok_den_nonzero, aclk, aresetn,
        m_valid && (m_status == STATUS_OK), m_sum_denominator != 63'd0,
        "good result with zero denominator")

    // An error result carries no fraction.
    `FSR_ASSERT_SAME(a_err_zero_payload, aclk, aresetn,
        m_valid && (m_status != STATUS_OK),
        (m_sum_numerator == 64'd0) && (m_sum_denominator == 63'd0),
        "error result with nonzero payload")

    // A zero sum is reported as 0/1.
    `FSR_ASSERT_SAME(a_zero_sum_form, aclk, aresetn,
        m_valid && (m_status == STATUS_OK) && (m_sum_numerator == 64'd0),
        m_sum_denominator == 63'd1,
        "zero sum not reported as 0/1")

    // A stalled result transfer holds its payload.
    `FSR_ASSERT_NEXT(a_out_hold, aclk, aresetn,
        m_valid && !m_ready,
        m_valid && $stable(m_sum_numerator) && $stable(m_sum_denominator) &&
            $stable(m_status),
        "stalled result changed")

    // An accepted fraction never carries unknown bits in its input word.
    `FSR_ASSERT_SAME(a_in_known, aclk, aresetn,
        in_xfer, !$isunknown(in_word),
        "input transfer with unknown payload")

endmodule

bind fraction_sum_reducer fsr_checker u_fsr_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_valid           (s_valid),
    .s_ready           (s_ready),
    .s_numerator       (s_numerator),
    .s_denominator     (s_denominator),
    .s_last            (s_last),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_sum_numerator   (m_sum_numerator),
    .m_sum_denominator (m_sum_denominator),
    .m_status          (m_status)
);

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fraction sum reducer testbench
// Drives runs of signed fractions through the reducer under several idle and
// stall mixes. A scoreboard keeps its own running sum for each run and checks
// every reduced total that comes out against it.
// ----------------------------------------------------------------------------
module tb;
    import fsr_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int QUIET_LIMIT  = 20000;
    localparam int PHASE_ITEMS  = 312;
    localparam int END_SETTLE   = 600;

    typedef struct {
        logic signed [63:0] num;
        logic        [62:0] den;
        logic        [1:0]  status;
    } reduced_sum_t;

    // Keeps a running rational sum per run and the queue of reduced totals
    // that the block still owes.
    class fraction_scoreboard;
        bit [63:0]    acc_num;
        bit [63:0]    acc_den;
        bit [1:0]     run_err;
        reduced_sum_t pending[$];
        int           errors;

        function new();
            clear_run();
            errors = 0;
        endfunction

        function void clear_run();
            acc_num = 64'd0;
            acc_den = 64'd1;
            run_err = STATUS_OK;
        endfunction

        function bit [63:0] gcd64(bit [63:0] a, bit [63:0] b);
            bit [63:0] t;
            while (b != 64'd0) begin
                t = a % b;
                a = b;
                b = t;
            end
            return a;
        endfunction

        function bit [63:0] magnitude(bit [63:0] v);
            return v[63] ? (64'd0 - v) : v;
        endfunction

        // Signed value times an unsigned factor; sets ovf if the product
        // leaves the signed 64-bit range.
        function bit [63:0] scale_signed(bit [63:0] a, bit [63:0] f, inout bit ovf);
            bit        neg;
            bit [63:0] m;
            bit [63:0] lim;
            bit [63:0] p;
            neg = a[63];
            m   = magnitude(a);
            lim = neg ? SIGN_MAG : MAX_POS;
            if (f != 64'd0 && m > lim / f) begin
                ovf = 1'b1;
                return 64'd0;
            end
            p = m * f;
            return neg ? (64'd0 - p) : p;
        endfunction

        function void add_fraction(bit [63:0] num, bit [63:0] den);
            bit [63:0] dm;
            bit [63:0] g;
            bit [63:0] q;
            bit [63:0] l;
            bit [63:0] t1;
            bit [63:0] t2;
            bit [63:0] s;
            bit        ovf;
            ovf = 1'b0;
            if (den == 64'd0) begin
                run_err = STATUS_ZERO_DEN;
                return;
            end
            // The sign of the denominator moves onto the numerator.
            if (den[63]) begin
                num = 64'd0 - num;
                dm  = 64'd0 - den;
            end else begin
                dm = den;
            end
            g = gcd64(acc_den, dm);
            q = acc_den / g;
            if (q > MAX_POS / dm) begin
                run_err = STATUS_OVERFLOW;
                return;
            end
            l  = q * dm;
            t1 = scale_signed(acc_num, l / acc_den, ovf);
            t2 = scale_signed(num, l / dm, ovf);
            s  = t1 + t2;
            if (!(t1[63] ^ t2[63]) && (s[63] ^ t1[63]))
                ovf = 1'b1;
            if (ovf) begin
                run_err = STATUS_OVERFLOW;
                return;
            end
            acc_num = s;
            acc_den = l;
        endfunction

        function void note_input(logic signed [31:0] n, logic signed [31:0] d, logic lst);
            reduced_sum_t r;
            bit           neg;
            bit [63:0]    m;
            bit [63:0]    g;
            bit [63:0]    rm;
            bit [63:0]    rd;
            if (run_err == STATUS_OK)
                add_fraction({{32{n[31]}}, n}, {{32{d[31]}}, d});
            if (!lst)
                return;
            if (run_err != STATUS_OK) begin
                r.num    = 64'sd0;
                r.den    = 63'd0;
                r.status = run_err;
            end else if (acc_num == 64'd0) begin
                r.num    = 64'sd0;
                r.den    = 63'd1;
                r.status = STATUS_OK;
            end else begin
                neg      = acc_num[63];
                m        = magnitude(acc_num);
                g        = gcd64(m, acc_den);
                rm       = m / g;
                rd       = acc_den / g;
                r.num    = neg ? (64'd0 - rm) : rm;
                r.den    = rd[62:0];
                r.status = STATUS_OK;
            end
            pending.push_back(r);
            clear_run();
        endfunction

        function void check_result(logic signed [63:0] n, logic [62:0] d, logic [1:0] s);
            reduced_sum_t e;
            if (pending.size() == 0) begin
                $display("%0t tb: unexpected result %0d/%0d status %0d", $time, n, d, s);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (n !== e.num) begin
                $display("%0t tb: sum_numerator expected %0d actual %0d", $time, e.num, n);
                errors++;
            end
            if (d !== e.den) begin
                $display("%0t tb: sum_denominator expected %0d actual %0d", $time, e.den, d);
                errors++;
            end
            if (s !== e.status) begin
                $display("%0t tb: status expected %0d actual %0d", $time, e.status, s);
                errors++;
            end
        endfunction
    endclass

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic signed [31:0] s_numerator;
    logic signed [31:0] s_denominator;
    logic               s_last;
    logic               m_valid;
    logic               m_ready;
    logic signed [63:0] m_sum_numerator;
    logic        [62:0] m_sum_denominator;
    logic        [1:0]  m_status;

    fraction_scoreboard sb = new();

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int items_sent   = 0;
    int quiet_cycles = 0;
    bit rx_enable    = 1'b0;

    fraction_sum_reducer i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_numerator       (s_numerator),
        .s_denominator     (s_denominator),
        .s_last            (s_last),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_sum_numerator   (m_sum_numerator),
        .m_sum_denominator (m_sum_denominator),
        .m_status          (m_status)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    always @(negedge aclk) begin
        if (rx_enable)
            m_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // Both channels are sampled here; the result check runs before the input
    // is noted so a total and the next run's first transfer can share a cycle.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                sb.check_result(m_sum_numerator, m_sum_denominator, m_status);
            if (s_valid && s_ready)
                sb.note_input(s_numerator, s_denominator, s_last);
            if ((m_valid && m_ready) || (s_valid && s_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("%0t tb: no transfer for %0d cycles", $time, QUIET_LIMIT);
        $display("tb: done, errors");
        $finish;
    end

    task automatic send_item(logic signed [31:0] n, logic signed [31:0] d, logic lst);
        @(negedge aclk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_numerator   <= n;
        s_denominator <= d;
        s_last        <= lst;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        items_sent++;
    endtask

    // Holds the sender off until every owed total has been taken.
    task automatic drain_results(int extra);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic send_random_run();
        int                 len;
        int                 kind;
        int                 bad_at;
        logic signed [31:0] n;
        logic signed [31:0] d;
        kind   = $urandom_range(99);
        len    = (kind < 55 || kind >= 93) ? $urandom_range(8, 1) : $urandom_range(4, 1);
        bad_at = (kind >= 93) ? $urandom_range(len - 1) : -1;
        for (int i = 0; i < len; i++) begin
            if (kind < 55 || kind >= 93) begin
                n = $urandom_range(16) - 8;
                d = $urandom_range(9, 1);
            end else if (kind < 75) begin
                n = $urandom_range(65535) - 32768;
                d = $urandom_range(65535, 1);
            end else begin
                n = $urandom;
                d = $urandom;
            end
            if (kind < 75 && $urandom_range(1))
                d = -d;
            if (i == bad_at)
                d = 32'sd0;
            send_item(n, d, i == len - 1);
        end
    endtask

    initial begin
        int tx_mix[4];
        int rx_mix[4];
        int total_errors;
        tx_mix = '{0, 68, 0, 9};
        rx_mix = '{0, 0, 68, 9};

        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_numerator   = 32'sd0;
        s_denominator = 32'sd1;
        s_last        = 1'b0;
        m_ready       = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn   <= 1'b1;
        rx_enable <= 1'b1;

        // Directed: extremes, sign handling, zero sum and the sticky errors.
        send_item(32'sd0, 32'sd1, 1'b1);
        send_item(32'sd3, 32'sd6, 1'b1);
        send_item(32'sd1, -32'sd2, 1'b1);
        send_item(32'h8000_0000, -32'sd1, 1'b1);
        send_item(32'sd2147483647, 32'h8000_0000, 1'b1);
        send_item(32'h8000_0000, 32'sd2147483647, 1'b1);
        send_item(32'sd1, 32'sd3, 1'b0);
        send_item(32'sd2, 32'sd3, 1'b1);
        send_item(32'sd1, 32'sd2, 1'b0);
        send_item(-32'sd1, 32'sd2, 1'b1);
        send_item(32'sd5, 32'sd0, 1'b1);
        send_item(32'sd1, 32'sd2, 1'b0);
        send_item(32'sd0, 32'sd0, 1'b0);
        send_item(32'sd1, 32'sd3, 1'b1);
        // Pairwise coprime denominators push the common multiple past 63 bits;
        // the zero denominator after that must not replace the first error.
        send_item(32'sd1, 32'sd2147483647, 1'b0);
        send_item(32'sd1, 32'sd2147483646, 1'b0);
        send_item(32'sd1, 32'sd2147483645, 1'b0);
        send_item(32'sd1, 32'sd0, 1'b1);
        // Large numerators grow the sum toward overflow, which the last fraction reaches.
        send_item(32'sd2147483647, 32'sd2147483646, 1'b0);
        send_item(32'sd2147483647, 32'sd3, 1'b0);
        send_item(32'sd2147483647, 32'sd3, 1'b0);
        send_item(32'h8000_0000, 32'h8000_0000, 1'b1);
        drain_results(50);

        for (int p = 0; p < 4; p++) begin
            tx_idle_pct  = tx_mix[p];
            rx_stall_pct = rx_mix[p];
            items_sent   = 0;
            while (items_sent < PHASE_ITEMS) begin
                send_random_run();
                if ($urandom_range(39) == 0)
                    drain_results($urandom_range(100));
            end
            drain_results($urandom_range(100));
        end

        drain_results(END_SETTLE);
        total_errors = sb.errors + sb.pending.size();
        if (sb.pending.size() != 0)
            $display("%0t tb: %0d expected results never arrived", $time, sb.pending.size());
        if (total_errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
